[hdl/fre_pkg.sv]
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types and constants of the Fibonacci residual encoder.
// ----------------------------------------------------------------------------
package fre_pkg;

  // Mapped residual value, 1 .. 65535.
  localparam int unsigned VAL_W = 16;
  // Fibonacci term width; the largest term does not fit in VAL_W.
  localparam int unsigned FIB_W = 17;
  // Term index, code register width and code length width.
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned CODE_W = 24;
  localparam int unsigned LEN_W  = 5;
  // Highest term the greedy scan tries; a hit there puts the stop bit at CODE_W-1.
  localparam logic [IDX_W-1:0] FIB_TOP = 5'd22;

  // Packing accumulator: 7 pending bits plus a full code.
  localparam int unsigned ACC_W = 31;
  localparam int unsigned CNT_W = 5;

  // Configuration port.
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_DROP_BITS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_REFERENCE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PACK,
    S_EMIT
  } state_t;

  // Result of one compare-and-subtract step against a Fibonacci term.
  typedef struct packed {
    logic             ge;
    logic [VAL_W-1:0] rem;
  } fib_step_t;

  function automatic logic [FIB_W-1:0] fib_term(input logic [IDX_W-1:0] idx);
    logic [FIB_W-1:0] term;
    unique case (idx)
      5'd0:  term = 17'd1;
      5'd1:  term = 17'd2;
      5'd2:  term = 17'd3;
      5'd3:  term = 17'd5;
      5'd4:  term = 17'd8;
      5'd5:  term = 17'd13;
      5'd6:  term = 17'd21;
      5'd7:  term = 17'd34;
      5'd8:  term = 17'd55;
      5'd9:  term = 17'd89;
      5'd10: term = 17'd144;
      5'd11: term = 17'd233;
      5'd12: term = 17'd377;
      5'd13: term = 17'd610;
      5'd14: term = 17'd987;
      5'd15: term = 17'd1597;
      5'd16: term = 17'd2584;
      5'd17: term = 17'd4181;
      5'd18: term = 17'd6765;
      5'd19: term = 17'd10946;
      5'd20: term = 17'd17711;
      5'd21: term = 17'd28657;
      5'd22: term = 17'd46368;
      5'd23: term = 17'd75025;
      default: term = '1;
    endcase
    return term;
  endfunction

endpackage

[hdl/fre_sample_if.sv]
// ----------------------------------------------------------------------------
// fre_sample_if
// Input channel: one digitizer sample per beat.
// ----------------------------------------------------------------------------
interface fre_sample_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

[hdl/fre_code_if.sv]
// ----------------------------------------------------------------------------
// fre_code_if
// Output channel: one packed code byte per beat.
// ----------------------------------------------------------------------------
interface fre_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

[hdl/fre_fib_step.sv]
// ----------------------------------------------------------------------------
// fre_fib_step
// Shared compare-and-subtract unit: tests a value against one Fibonacci term.
// ----------------------------------------------------------------------------
module fre_fib_step (
  input  logic [fre_pkg::VAL_W-1:0] value,
  input  logic [fre_pkg::IDX_W-1:0] idx,
  output fre_pkg::fib_step_t        step
);

  logic [fre_pkg::FIB_W-1:0] term;
  logic [fre_pkg::FIB_W-1:0] wide;
  logic [fre_pkg::FIB_W-1:0] diff;

  assign term = fre_pkg::fib_term(idx);
  assign wide = fre_pkg::FIB_W'(value);
  assign diff = wide - term;

  assign step.ge  = (wide >= term);
  assign step.rem = diff[fre_pkg::VAL_W-1:0];

endmodule

[hdl/fibonacci_residual_encoder.sv]
// ----------------------------------------------------------------------------
// fibonacci_residual_encoder
// Zigzag-maps the residual of each shifted sample against a reference and
// packs its Fibonacci code LSB-first into bytes.
// ----------------------------------------------------------------------------
//
//   channel   dir  beat payload                      handshake
//   samples   in   sample, last_sample               valid / ready
//   codes     out  code_byte, last_byte              valid / ready
//   cfg       in   drop_bits @ 0x0, reference @ 0x4  APB (psel, penable)
//
// One sample is worked at a time. The accept cycle maps the sample, then the
// shared compare/subtract unit runs the greedy Zeckendorf scan over 23 terms,
// one term per cycle, the pack state merges the code with the pending bits,
// and the emit state offers each output byte and at its end stores the
// leftover. A sample with every bit dropped skips the scan. The scan steps
// through the terms on the single shared unit. Reset (rst, synchronous)
// clears the configuration registers, the pending bits and the sequencer,
// not the datapath registers. A stalled output holds the sequencer in its
// emit state with the byte steady; samples.ready is low until every byte of
// the current sample has left.
// ----------------------------------------------------------------------------
module fibonacci_residual_encoder #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  fre_sample_if.sink                     samples,
  fre_code_if.source                     codes,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fre_pkg::ADDR_W-1:0]     paddr,
  input  logic [fre_pkg::DATA_W-1:0]     pwdata,
  output logic [fre_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  // The residual spans the wider of the shifted sample and the reference, plus sign.
  localparam int unsigned MAG_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int unsigned RES_W = MAG_W + 1;

  // Configuration registers.
  logic [3:0]  drop_bits;
  logic [11:0] reference;

  // Sequencer and datapath registers.
  fre_pkg::state_t                state;
  fre_pkg::state_t                state_next;
  logic [fre_pkg::VAL_W-1:0]      value;
  logic [fre_pkg::IDX_W-1:0]      k;
  logic [fre_pkg::CODE_W-1:0]     code;
  logic                           seen;
  logic [fre_pkg::LEN_W-1:0]      len;
  logic                           last_q;
  logic [fre_pkg::ACC_W-1:0]      acc;
  logic [fre_pkg::CNT_W-1:0]      cnt;
  logic [6:0]                     partial_byte;
  logic [2:0]                     partial_count;

  // APB write strobe and register select.
  logic                           cfg_write;
  logic [fre_pkg::REG_IDX_W-1:0]  reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      fre_pkg::REG_DROP_BITS: prdata = fre_pkg::DATA_W'(drop_bits);
      fre_pkg::REG_REFERENCE: prdata = fre_pkg::DATA_W'(reference);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_bits <= '0;
      reference <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        fre_pkg::REG_DROP_BITS: drop_bits <= pwdata[3:0];
        fre_pkg::REG_REFERENCE: reference <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Front end: shift, subtract the reference, and zigzag map to a positive value.
  // When every sample bit is dropped there is nothing to code for this sample.
  logic                   in_fire;
  logic                   coding;
  logic [SAMPLE_BITS-1:0] shifted;
  logic signed [RES_W-1:0] resid;
  logic [RES_W-1:0]       neg_resid;
  logic [MAG_W-1:0]       mag;
  logic [fre_pkg::VAL_W-1:0] mapped;

  assign in_fire   = samples.valid && samples.ready;
  assign coding    = (drop_bits < 4'(SAMPLE_BITS));
  assign shifted   = samples.sample >> drop_bits;
  assign resid     = $signed({1'b0, MAG_W'(shifted)}) - $signed({1'b0, MAG_W'(reference)});
  assign neg_resid = -resid;
  assign mag       = resid[RES_W-1] ? neg_resid[MAG_W-1:0] : resid[MAG_W-1:0];
  assign mapped    = fre_pkg::VAL_W'({mag, ~resid[RES_W-1]});

  // The one shared compare/subtract unit used by the scan.
  fre_pkg::fib_step_t step;

  fre_fib_step u_step (
    .value (value),
    .idx   (k),
    .step  (step)
  );

  // Emit decisions: a full byte goes out first; a marked last sample then
  // flushes whatever bits remain as one padded byte.
  logic has_full;
  logic has_flush;
  logic emit_done;
  logic out_fire;

  assign has_full  = (cnt >= fre_pkg::CNT_W'(8));
  assign has_flush = last_q && (cnt != '0) && !has_full;
  assign emit_done = (state == fre_pkg::S_EMIT) && !has_full && !has_flush;
  assign out_fire  = codes.valid && codes.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fre_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = coding ? fre_pkg::S_SCAN : fre_pkg::S_PACK;
        end
      end
      fre_pkg::S_SCAN: begin
        if (k == '0) begin
          state_next = fre_pkg::S_PACK;
        end
      end
      fre_pkg::S_PACK: state_next = fre_pkg::S_EMIT;
      fre_pkg::S_EMIT: begin
        if (emit_done) begin
          state_next = fre_pkg::S_IDLE;
        end
      end
      default: state_next = fre_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    samples.ready   = (state == fre_pkg::S_IDLE);
    codes.valid     = (state == fre_pkg::S_EMIT) && (has_full || has_flush);
    codes.code_byte = acc[7:0];
    // On a last sample, the byte is the final one when nothing remains behind it.
    codes.last_byte = last_q && (cnt <= fre_pkg::CNT_W'(8));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fre_pkg::S_IDLE;
      partial_byte  <= '0;
      partial_count <= '0;
    end else begin
      state <= state_next;
      if (emit_done) begin
        partial_byte  <= last_q ? 7'd0 : acc[6:0];
        partial_count <= last_q ? 3'd0 : cnt[2:0];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      fre_pkg::S_IDLE: begin
        if (in_fire) begin
          value  <= mapped;
          last_q <= samples.last_sample;
          k      <= fre_pkg::FIB_TOP;
          code   <= '0;
          seen   <= 1'b0;
          len    <= '0;
        end
      end
      fre_pkg::S_SCAN: begin
        // Greedy Zeckendorf from the top term down. The first hit fixes the
        // code length and places the stop bit one position above it.
        if (step.ge) begin
          value   <= step.rem;
          code[k] <= 1'b1;
          if (!seen) begin
            code[fre_pkg::IDX_W'(k + 1'b1)] <= 1'b1;
            len  <= fre_pkg::LEN_W'(k + 2'd2);
            seen <= 1'b1;
          end
        end
        k <= k - 1'b1;
      end
      fre_pkg::S_PACK: begin
        acc <= fre_pkg::ACC_W'(partial_byte)
             | (fre_pkg::ACC_W'(code) << partial_count);
        cnt <= fre_pkg::CNT_W'(partial_count) + len;
      end
      fre_pkg::S_EMIT: begin
        if (out_fire) begin
          acc <= acc >> 8;
          cnt <= has_full ? cnt - fre_pkg::CNT_W'(8) : '0;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // No byte is offered while a new sample can be taken.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !codes.valid)
    else $error("sample ready while a code byte is offered");

  // The scan visits one term per cycle, from the top down.
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    (state == fre_pkg::S_SCAN) && (k != '0) |=> (k == $past(k) - 1'b1))
    else $error("scan index did not step down by one");

  // Only a partial byte is carried into the next sample.
  a_leftover: assert property (@(posedge clk) disable iff (rst)
    emit_done |-> (cnt < fre_pkg::CNT_W'(8)))
    else $error("full byte left behind at end of sample");

  // A last sample leaves nothing pending.
  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    emit_done && last_q |=> (partial_count == '0) && (partial_byte == '0))
    else $error("pending bits survived a last sample");

  // A found code is at least the two-bit stop pattern long.
  a_code_len: assert property (@(posedge clk) disable iff (rst)
    (state == fre_pkg::S_PACK) && seen |-> (len >= fre_pkg::LEN_W'(2)))
    else $error("code length shorter than stop pattern");
`endif

endmodule
